/* rtl/core/ncrf_pkg.sv */
package ncrf_pkg;

	localparam int COORD_WIDTH = 40;
	localparam int FRAC_BITS   = 36;
	localparam int ITER_WIDTH  = 16;

	localparam int QF        = 40;
	localparam int DIV_STEPS = 64 + QF;
	localparam int SH_R      = (FRAC_BITS >= QF) ? FRAC_BITS - QF : 0;
	localparam int SH_L      = (FRAC_BITS >= QF) ? 0 : QF - FRAC_BITS;

	localparam logic [ITER_WIDTH-1:0] ITER_RESET = ITER_WIDTH'(256);

	localparam logic signed [63:0] ONE_Q    = 64'sd1099511627776;
	localparam logic signed [63:0] HALF_Q   = 64'sd549755813888;
	localparam logic signed [63:0] ROOT_IM  = 64'sd952205001410;
	localparam logic signed [63:0] TOL2_LIM = 64'sd10996;
	localparam logic signed [63:0] MAG_MIN  = 64'sd3665039;
	localparam logic [64:0]        BAIL2    = 65'd10995116277760000;
	localparam logic [20:0]        TOL_LOG2 = 21'd879793;
	localparam logic [21:0]        EXTRA_MAX = 22'd2097152;
	localparam logic [63:0]        RECIP3   = 64'hAAAAAAAAAAAAAAAB;
	localparam logic [63:0]        INT64_MAX = 64'h7FFFFFFFFFFFFFFF;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] pixel_re;
		logic signed [COORD_WIDTH-1:0] pixel_im;
	} pixel_t;

	typedef struct packed {
		logic [31:0] smooth_count;
		logic [1:0]  outcome;
	} result_t;

	typedef enum logic [1:0] {
		OUT_CONV  = 2'd0,
		OUT_LIMIT = 2'd1,
		OUT_DERIV = 2'd2,
		OUT_BAIL  = 2'd3
	} outcome_t;

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_CHECK, S_DX1, S_DY1, S_DX2, S_DY2, S_DY3, S_DEC,
		S_LOG1, S_LOG2, S_MX, S_MCHK, S_DIVX, S_DIVY, S_WXX, S_WYY, S_WXY,
		S_X3, S_Y3, S_BX, S_BY, S_DONE
	} state_t;

	typedef struct packed {
		logic              ok;
		logic signed [63:0] val;
	} coord_t;

	function automatic logic [63:0] umag(input logic signed [63:0] a);
		return a[63] ? 64'(-a) : 64'(a);
	endfunction

	function automatic logic signed [63:0] sat_sign(input logic [63:0] mag, input logic neg);
		logic [63:0] m;
		m = (mag > INT64_MAX) ? INT64_MAX : mag;
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] q40(input logic [127:0] prod, input logic neg);
		logic [63:0] m;
		m = (|prod[127:104]) ? INT64_MAX : prod[103:40];
		return sat_sign(m, neg);
	endfunction

	function automatic logic [31:0] sat32(input logic [63:0] v);
		return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
	endfunction

	function automatic logic [16:0] log_tab(input logic [4:0] idx);
		logic [16:0] r;
		unique case (idx)
			5'd0:  r = 17'd0;
			5'd1:  r = 17'd5732;
			5'd2:  r = 17'd11136;
			5'd3:  r = 17'd16248;
			5'd4:  r = 17'd21098;
			5'd5:  r = 17'd25711;
			5'd6:  r = 17'd30109;
			5'd7:  r = 17'd34312;
			5'd8:  r = 17'd38336;
			5'd9:  r = 17'd42196;
			5'd10: r = 17'd45904;
			5'd11: r = 17'd49472;
			5'd12: r = 17'd52911;
			5'd13: r = 17'd56229;
			5'd14: r = 17'd59434;
			5'd15: r = 17'd62534;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

	function automatic coord_t load_q40(input logic [COORD_WIDTH-1:0] raw);
		coord_t c;
		logic [COORD_WIDTH-1:0] mag;
		logic [63:0] m64;
		mag = raw[COORD_WIDTH-1] ? (~raw + 1'b1) : raw;
		m64 = 64'(mag);
		c.ok = (m64 >> FRAC_BITS) < 64'd256;
		m64 = (FRAC_BITS >= QF) ? (m64 >> SH_R) : (m64 << SH_L);
		c.val = sat_sign(m64, raw[COORD_WIDTH-1]);
		return c;
	endfunction

endpackage

/* rtl/core/ncrf_mul.sv */
module ncrf_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         busy,
	output logic         done,
	output logic [127:0] prod
);
	logic [63:0]  a_q, b_q;
	logic [2:0]   step_q;
	logic [63:0]  pp_s1;
	logic [1:0]   sh_s1;
	logic [127:0] acc_q;
	logic         busy_q, done_q;
	logic [31:0]  a_part, b_part;

	assign a_part = step_q[0] ? a_q[63:32] : a_q[31:0];
	assign b_part = step_q[1] ? b_q[63:32] : b_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q != 3'd4) begin
				pp_s1 <= a_part * b_part;
				sh_s1 <= 2'(step_q[0]) + 2'(step_q[1]);
			end
			if (step_q != 3'd0)
				acc_q <= acc_q + (128'(pp_s1) << {sh_s1, 5'b0});
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;
endmodule

/* rtl/core/ncrf_div.sv */
module ncrf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        busy,
	output logic        done,
	output logic [63:0] quo
);
	import ncrf_pkg::*;

	logic [DIV_STEPS-1:0] dvd_q;
	logic [63:0] rem_q, quo_q, den_q;
	logic [6:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] r2, rdiff;
	logic        ge;

	assign r2    = {rem_q, dvd_q[DIV_STEPS-1]};
	assign rdiff = r2 - {1'b0, den_q};
	assign ge    = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, {QF{1'b0}}};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rdiff[63:0] : r2[63:0];
			quo_q <= {quo_q[62:0], ge};
			dvd_q <= {dvd_q[DIV_STEPS-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
endmodule

/* rtl/core/newton_cubic_root_fractal.sv */
// Channel   Direction  Handshake                        Payload
// pixel     in         pixel_valid / pixel_ready        ncrf_pkg::pixel_t
// result    out        result_valid / result_ready      ncrf_pkg::result_t
// config    in         APB psel/penable/pwrite, pready  max_iterations at byte address 0
//
// One item is worked on at a time; each Newton iteration is made of thirteen passes through the
// shared multiplier, two divisions and three decision states.
// An item that converges ends with its last distance tests and the smooth count.
// Reset clears the sequencer, the result valid flag and sets the limit to 256.
// A finished result waits in its output register while the next item is accepted.
module newton_cubic_root_fractal (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_ready,
	input  ncrf_pkg::pixel_t pixel,
	output logic             result_valid,
	input  logic             result_ready,
	output ncrf_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import ncrf_pkg::*;

	state_t state_q, state_d;

	logic [ITER_WIDTH-1:0] max_iter_q, limit_q, iter_q;
	logic signed [63:0] x_q, y_q, t_q, yy_q, d_q, m_q, wx_q, wy_q, w2x_q, w2y_q;
	logic        ok_q, res_valid_q, zero_q;
	logic [31:0] count_q;
	outcome_t    outcome_q;
	result_t     res_q;
	logic [3:0]  p_q, idx_q;
	logic [15:0] rem_q;

	logic        mul_go, mul_start, mul_busy, mul_done;
	logic [63:0] mul_a, mul_b;
	logic [127:0] mul_prod;
	logic        div_go, div_start, div_busy, div_done;
	logic [63:0] div_num, div_quo;

	coord_t lx, ly;
	logic signed [63:0] sq, sq_n, dsum, t3x, t3y;
	logic [63:0] q3, limit_count;
	logic [64:0] bsum;
	logic [13:0] lv, norm;
	logic [3:0]  lp;
	logic [16:0] tab_lo, tab_hi;
	logic [32:0] interp;
	logic [20:0] lg;
	logic [19:0] diff;
	logic [21:0] extra;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : 32'(max_iter_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_iter_q <= ITER_RESET;
		else if (psel && penable && pwrite && !paddr[2])
			max_iter_q <= pwdata[ITER_WIDTH-1:0];
	end

	ncrf_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .done(mul_done), .prod(mul_prod)
	);

	ncrf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(64'(m_q)),
		.busy(div_busy), .done(div_done), .quo(div_quo)
	);

	assign mul_start = mul_go && !mul_busy && !mul_done;
	assign div_start = div_go && !div_busy && !div_done;

	assign lx   = load_q40(pixel.pixel_re);
	assign ly   = load_q40(pixel.pixel_im);
	assign sq   = q40(mul_prod, 1'b0);
	assign sq_n = q40(mul_prod, wx_q[63] ^ wy_q[63]);
	assign dsum = t_q + sq;
	assign t3x  = x_q + x_q + w2x_q;
	assign t3y  = y_q + y_q + w2y_q;
	assign q3   = {1'b0, mul_prod[127:65]};
	assign bsum = {1'b0, t_q} + {1'b0, sq};
	assign limit_count = 64'(limit_q) << 16;

	always_comb begin
		lv = d_q[13:0];
		lp = '0;
		for (int i = 0; i < 14; i++)
			if (lv[i])
				lp = 4'(i);
		norm = lv << (4'd13 - lp);
	end

	assign tab_lo = log_tab({1'b0, idx_q});
	assign tab_hi = log_tab({1'b0, idx_q} + 5'd1);
	assign interp = (tab_hi - tab_lo) * rem_q;
	assign lg     = {1'b0, p_q, 16'b0} + 21'(tab_lo) + 21'(interp[32:16]);
	assign diff   = (TOL_LOG2 > lg) ? 20'(TOL_LOG2 - lg) : 20'd0;

	always_comb begin
		extra = 22'd65536 + 22'(diff >> 1);
		if (zero_q || extra > EXTRA_MAX)
			extra = EXTRA_MAX;
	end

	always_comb begin
		state_d = state_q;
		mul_go  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		div_go  = 1'b0;
		div_num = '0;
		unique case (state_q)
			S_IDLE: if (pixel_valid) state_d = S_START;
			S_START: begin
				if (limit_q != '0 && !ok_q)
					state_d = S_DONE;
				else
					state_d = S_CHECK;
			end
			S_CHECK: state_d = (iter_q < limit_q) ? S_DX1 : S_DONE;
			S_DX1: begin
				mul_go = 1'b1;
				mul_a  = umag(x_q - ONE_Q);
				mul_b  = mul_a;
				if (mul_done) state_d = S_DY1;
			end
			S_DY1: begin
				mul_go = 1'b1;
				mul_a  = umag(y_q);
				mul_b  = mul_a;
				if (mul_done) state_d = S_DX2;
			end
			S_DX2: begin
				mul_go = 1'b1;
				mul_a  = umag(x_q + HALF_Q);
				mul_b  = mul_a;
				if (mul_done) state_d = S_DY2;
			end
			S_DY2: begin
				mul_go = 1'b1;
				mul_a  = umag(y_q - ROOT_IM);
				mul_b  = mul_a;
				if (mul_done) state_d = S_DY3;
			end
			S_DY3: begin
				mul_go = 1'b1;
				mul_a  = umag(y_q + ROOT_IM);
				mul_b  = mul_a;
				if (mul_done) state_d = S_DEC;
			end
			S_DEC:  state_d = (d_q < TOL2_LIM) ? S_LOG1 : S_MX;
			S_LOG1: state_d = S_LOG2;
			S_LOG2: state_d = S_DONE;
			S_MX: begin
				mul_go = 1'b1;
				mul_a  = umag(x_q);
				mul_b  = mul_a;
				if (mul_done) state_d = S_MCHK;
			end
			S_MCHK: state_d = (m_q < MAG_MIN) ? S_DONE : S_DIVX;
			S_DIVX: begin
				div_go  = 1'b1;
				div_num = umag(x_q);
				if (div_done) state_d = S_DIVY;
			end
			S_DIVY: begin
				div_go  = 1'b1;
				div_num = umag(y_q);
				if (div_done) state_d = S_WXX;
			end
			S_WXX: begin
				mul_go = 1'b1;
				mul_a  = umag(wx_q);
				mul_b  = mul_a;
				if (mul_done) state_d = S_WYY;
			end
			S_WYY: begin
				mul_go = 1'b1;
				mul_a  = umag(wy_q);
				mul_b  = mul_a;
				if (mul_done) state_d = S_WXY;
			end
			S_WXY: begin
				mul_go = 1'b1;
				mul_a  = umag(wx_q);
				mul_b  = umag(wy_q);
				if (mul_done) state_d = S_X3;
			end
			S_X3: begin
				mul_go = 1'b1;
				mul_a  = umag(t3x);
				mul_b  = RECIP3;
				if (mul_done) state_d = S_Y3;
			end
			S_Y3: begin
				mul_go = 1'b1;
				mul_a  = umag(t3y);
				mul_b  = RECIP3;
				if (mul_done) state_d = S_BX;
			end
			S_BX: begin
				mul_go = 1'b1;
				mul_a  = umag(x_q);
				mul_b  = mul_a;
				if (mul_done) state_d = S_BY;
			end
			S_BY: begin
				mul_go = 1'b1;
				mul_a  = umag(y_q);
				mul_b  = mul_a;
				if (mul_done) state_d = (bsum > BAIL2) ? S_DONE : S_CHECK;
			end
			S_DONE: if (!res_valid_q || result_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && (!res_valid_q || result_ready))
				res_valid_q <= 1'b1;
			else if (result_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (pixel_valid) begin
					x_q     <= lx.val;
					y_q     <= ly.val;
					ok_q    <= lx.ok && ly.ok;
					limit_q <= max_iter_q;
					iter_q  <= '0;
				end
			end
			S_START: begin
				outcome_q <= OUT_BAIL;
				count_q   <= sat32(limit_count);
			end
			S_CHECK: begin
				outcome_q <= OUT_LIMIT;
				count_q   <= sat32(limit_count);
			end
			S_DX1: if (mul_done) t_q <= sq;
			S_DY1: if (mul_done) begin
				yy_q <= sq;
				d_q  <= dsum;
			end
			S_DX2: if (mul_done) t_q <= sq;
			S_DY2, S_DY3: if (mul_done && dsum < d_q) d_q <= dsum;
			S_LOG1: begin
				p_q    <= lp;
				idx_q  <= norm[12:9];
				rem_q  <= {norm[8:0], 7'b0};
				zero_q <= (d_q <= 64'sd0);
			end
			S_LOG2: begin
				outcome_q <= OUT_CONV;
				count_q   <= sat32(64'({iter_q, 16'b0}) + 64'(extra));
			end
			S_MX: if (mul_done) m_q <= sq + yy_q;
			S_MCHK: begin
				outcome_q <= OUT_DERIV;
				count_q   <= sat32(limit_count);
			end
			S_DIVX: if (div_done) wx_q <= sat_sign(div_quo, x_q[63]);
			S_DIVY: if (div_done) wy_q <= sat_sign(div_quo, !y_q[63]);
			S_WXX: if (mul_done) t_q <= sq;
			S_WYY: if (mul_done) w2x_q <= t_q - sq;
			S_WXY: if (mul_done) w2y_q <= {sq_n[62:0], 1'b0};
			S_X3: if (mul_done) x_q <= t3x[63] ? -$signed(q3) : $signed(q3);
			S_Y3: if (mul_done) y_q <= t3y[63] ? -$signed(q3) : $signed(q3);
			S_BX: if (mul_done) t_q <= sq;
			S_BY: if (mul_done) begin
				outcome_q <= OUT_BAIL;
				count_q   <= sat32(limit_count);
				iter_q    <= iter_q + 1'b1;
			end
			S_DONE: begin
				if (!res_valid_q || result_ready) begin
					res_q.smooth_count <= count_q;
					res_q.outcome      <= outcome_q;
				end
			end
			default: ;
		endcase
	end

	assign pixel_ready  = (state_q == S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;
endmodule
